FILE: design/thermistor_temperature_lookup_macros.svh
// Assertion macros used by the thermistor lookup checker.
`ifndef THERMISTOR_TEMPERATURE_LOOKUP_MACROS_SVH
`define THERMISTOR_TEMPERATURE_LOOKUP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ttl_pkg.sv
// Package: constants, resistance table and controller/datapath interface types.
package ttl_pkg;

   localparam int ROM_LEN    = 101;
   localparam int IDX_W      = $clog2(ROM_LEN);
   localparam int SAMPLE_W   = 12;
   localparam int TEMP_OUT_W = 15;
   localparam int RES_W      = 16;
   localparam int STATUS_W   = 2;

   localparam int TABLE_ENTRIES_DEF = 101;
   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int FRACTION_BITS_DEF = 8;

   localparam logic [RES_W-1:0] DIVIDER_RESET = 16'd10000;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_COLD = 2'd1;
   localparam status_type STATUS_HOT  = 2'd2;
   localparam status_type STATUS_ZERO = 2'd3;

   // Thermistor resistance in ohms, one entry per degree from 0 upward.
   localparam logic [RES_W-1:0] NTC_ROM [ROM_LEN] = '{
      16'd32754, 16'd31124, 16'd29584, 16'd28130, 16'd26755, 16'd25456, 16'd24227,
      16'd23065, 16'd21965, 16'd20923, 16'd19938, 16'd19004, 16'd18119, 16'd17280,
      16'd16485, 16'd15731, 16'd15016, 16'd14337, 16'd13693, 16'd13081, 16'd12500,
      16'd11948, 16'd11423, 16'd10925, 16'd10451, 16'd10000, 16'd9570,  16'd9162,
      16'd8773,  16'd8403,  16'd8051,  16'd7715,  16'd7395,  16'd7090,  16'd6799,
      16'd6522,  16'd6257,  16'd6005,  16'd5764,  16'd5534,  16'd5314,  16'd5104,
      16'd4904,  16'd4713,  16'd4530,  16'd4355,  16'd4187,  16'd4027,  16'd3874,
      16'd3728,  16'd3588,  16'd3454,  16'd3325,  16'd3202,  16'd3084,  16'd2971,
      16'd2863,  16'd2759,  16'd2660,  16'd2564,  16'd2473,  16'd2385,  16'd2301,
      16'd2220,  16'd2143,  16'd2068,  16'd1997,  16'd1928,  16'd1862,  16'd1798,
      16'd1738,  16'd1679,  16'd1623,  16'd1568,  16'd1516,  16'd1466,  16'd1418,
      16'd1372,  16'd1327,  16'd1284,  16'd1243,  16'd1203,  16'd1164,  16'd1127,
      16'd1092,  16'd1058,  16'd1024,  16'd993,   16'd962,   16'd932,   16'd904,
      16'd876,   16'd849,   16'd824,   16'd799,   16'd775,   16'd752,   16'd730,
      16'd708,   16'd687,   16'd667
   };

   function automatic logic [RES_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
      logic [RES_W-1:0] val;
      val = '0;
      if (int'(idx) < ROM_LEN) begin
         val = NTC_ROM[idx];
      end
      return val;
   endfunction

   // Commands from the controller, one datapath operation each.
   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic classify;
      logic search_step;
      logic div2_init;
      logic finish;
      logic set_zero;
   } ctl_cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic zero_sample;
      logic in_range;
      logic search_done;
   } dp_stat_type;

endpackage

FILE: design/ttl_ctrl.sv
// Controller: sequences multiply, divide, search and interpolate steps.
module ttl_ctrl import ttl_pkg::*; #(
   parameter int DIV_W = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd,
   output logic        busy,
   output logic        rsp_valid
);

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_DIV1   = 8'b0000_0100,
      ST_CLASS  = 8'b0000_1000,
      ST_SEARCH = 8'b0001_0000,
      ST_DIV2   = 8'b0010_0000,
      ST_FINISH = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (stat.zero_sample) begin
               cmd.set_zero = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.mul  = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = stat.in_range ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            if (stat.search_done) begin
               cmd.div2_init = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV2;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

FILE: design/ttl_dpath.sv
// Datapath: divider register, multiplier, shared restoring divider, search and result regs.
module ttl_dpath import ttl_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int N_EFF         = TABLE_ENTRIES_DEF,
   parameter int DIV_W         = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [RES_W-1:0]      csr_wr_data,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  ctl_cmd_type           cmd,
   output dp_stat_type           stat,
   output logic [TEMP_OUT_W-1:0] rsp_temperature_q8,
   output logic [RES_W-1:0]      rsp_resistance_ohms,
   output status_type            rsp_status
);

   localparam int NUM_W  = RES_W + SAMPLE_BITS;
   localparam int TEMP_W = (IDX_W + FRACTION_BITS + 1 > TEMP_OUT_W) ?
                           (IDX_W + FRACTION_BITS + 1) : TEMP_OUT_W;
   localparam logic [IDX_W-1:0]       LAST_IDX   = IDX_W'(N_EFF - 1);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

   logic [RES_W-1:0]       divider_ff, divider_in;
   logic [SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic                   zero_ff, zero_in;
   logic [RES_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [RES_W-1:0]       dsor_ff, dsor_in;
   logic [RES_W-1:0]       r_ff, r_in;
   logic [IDX_W-1:0]       lo_ff, lo_in;
   logic [IDX_W-1:0]       hi_ff, hi_in;
   logic                   den_zero_ff, den_zero_in;
   logic [TEMP_OUT_W-1:0]  temp_ff, temp_in;
   logic [RES_W-1:0]       res_ff, res_in;
   status_type             stat_ff, stat_in;

   logic [NUM_W-1:0]  prod;
   logic [RES_W:0]    div_trial;
   logic              div_ge;
   logic [RES_W-1:0]  sat_r;
   logic [RES_W-1:0]  rom_first;
   logic [RES_W-1:0]  rom_last;
   logic [IDX_W-1:0]  mid;
   logic [RES_W-1:0]  lov;
   logic [RES_W-1:0]  hiv;
   logic [RES_W-1:0]  den;
   logic [TEMP_W-1:0] temp_interp;
   logic [TEMP_W-1:0] temp_hot;

   assign prod      = NUM_W'(divider_ff) * NUM_W'(FULL_SCALE - samp_ff);
   assign div_trial = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, dsor_ff});
   assign sat_r     = (|quo_ff[DIV_W-1:RES_W]) ? '1 : quo_ff[RES_W-1:0];
   assign rom_first = rom_read('0);
   assign rom_last  = rom_read(LAST_IDX);
   assign mid       = IDX_W'(lo_ff + ((hi_ff - lo_ff) >> 1));
   assign lov       = rom_read(lo_ff);
   assign hiv       = rom_read(hi_ff);
   assign den       = lov - hiv;
   assign temp_hot  = TEMP_W'(LAST_IDX) << FRACTION_BITS;
   assign temp_interp = (TEMP_W'(lo_ff) << FRACTION_BITS) +
                        (den_zero_ff ? '0 : TEMP_W'(quo_ff));

   assign stat.zero_sample = zero_ff;
   assign stat.in_range    = (sat_r < rom_first) && (sat_r > rom_last);
   assign stat.search_done = ((hi_ff - lo_ff) <= IDX_W'(1));

   always_comb begin
      divider_in  = divider_ff;
      samp_in     = samp_ff;
      zero_in     = zero_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dsor_in     = dsor_ff;
      r_in        = r_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      den_zero_in = den_zero_ff;
      temp_in     = temp_ff;
      res_in      = res_ff;
      stat_in     = stat_ff;

      if (csr_wr_en) begin
         divider_in = csr_wr_data;
      end

      if (cmd.load) begin
         samp_in = SAMPLE_BITS'(req_sample);
         zero_in = (SAMPLE_BITS'(req_sample) == '0);
      end

      // first division: resistance = product / sample
      if (cmd.mul) begin
         quo_in  = DIV_W'(prod);
         rem_in  = '0;
         dsor_in = RES_W'(samp_ff);
      end

      // one restoring step, quotient bit shifts in at the bottom
      if (cmd.div_step) begin
         rem_in = div_ge ? RES_W'(div_trial - {1'b0, dsor_ff}) : div_trial[RES_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], div_ge};
      end

      if (cmd.classify) begin
         r_in   = sat_r;
         res_in = sat_r;
         lo_in  = '0;
         hi_in  = LAST_IDX;
         if (sat_r >= rom_first) begin
            temp_in = '0;
            stat_in = (sat_r > rom_first) ? STATUS_COLD : STATUS_OK;
         end else if (sat_r <= rom_last) begin
            temp_in = temp_hot[TEMP_OUT_W-1:0];
            stat_in = (sat_r < rom_last) ? STATUS_HOT : STATUS_OK;
         end else begin
            stat_in = STATUS_OK;
         end
      end

      // keeps rom[lo] >= r > rom[hi]
      if (cmd.search_step) begin
         if (rom_read(mid) >= r_ff) begin
            lo_in = mid;
         end else begin
            hi_in = mid;
         end
      end

      // second division: fraction within the bracketing segment
      if (cmd.div2_init) begin
         quo_in      = DIV_W'(lov - r_ff) << FRACTION_BITS;
         rem_in      = '0;
         dsor_in     = den;
         den_zero_in = (den == '0);
      end

      if (cmd.finish) begin
         temp_in = temp_interp[TEMP_OUT_W-1:0];
      end

      if (cmd.set_zero) begin
         temp_in = '0;
         res_in  = '1;
         stat_in = STATUS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= DIVIDER_RESET;
      end else begin
         divider_ff <= divider_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      zero_ff     <= zero_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsor_ff     <= dsor_in;
      r_ff        <= r_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      den_zero_ff <= den_zero_in;
      temp_ff     <= temp_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
   end

   assign rsp_temperature_q8  = temp_ff;
   assign rsp_resistance_ohms = res_ff;
   assign rsp_status          = stat_ff;

endmodule

FILE: design/thermistor_temperature_lookup.sv
// Top level: NTC thermistor sample to resistance and interpolated temperature.
//
// Usage:
//   Request: drive req_sample and raise start; the beat is taken at a rising
//   edge with start high and busy low. busy stays high until the result beat.
//   Result: rsp_valid is high for exactly one cycle, carrying
//   rsp_temperature_q8 (degrees * 2^FRACTION_BITS), rsp_resistance_ohms and
//   rsp_status. The receiver cannot stall; the beat is gone after that cycle.
//   CSR: csr_wr_en/csr_wr_data write divider_ohms (write only while idle).
// Sequence from accept to the result beat, with
// DIV_W = 16 + max(SAMPLE_BITS, FRACTION_BITS), 28 by default:
//   zero sample:            straight to the result
//   clamped at a table end: first division, classify, result
//   interpolated:           first division, classify, search, second division, finish, result
//   One item at a time; the next is taken the cycle after the result beat.
//   A single restoring divider, one quotient bit per cycle, serves both
//   divisions: once for resistance and once for the fraction.
// Reset (synchronous, active high) returns to idle and sets divider_ohms to
// 10000; an item in flight is dropped.
module thermistor_temperature_lookup import ttl_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  csr_wr_en,
   input  logic [RES_W-1:0]      csr_wr_data,
   output logic                  rsp_valid,
   output logic [TEMP_OUT_W-1:0] rsp_temperature_q8,
   output logic [RES_W-1:0]      rsp_resistance_ohms,
   output status_type            rsp_status
);

   // Table length limited to the stored entries, at least two.
   localparam int N_EFF = (TABLE_ENTRIES > ROM_LEN) ? ROM_LEN :
                          ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
   // Divider width covers both dividends: divider*(FS-sample) and diff << FRACTION_BITS.
   localparam int DIV_W = (SAMPLE_BITS > FRACTION_BITS) ? (RES_W + SAMPLE_BITS) :
                          (RES_W + FRACTION_BITS);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   ttl_ctrl #(
      .DIV_W (DIV_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ttl_dpath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .N_EFF         (N_EFF),
      .DIV_W         (DIV_W)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_sample          (req_sample),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_temperature_q8  (rsp_temperature_q8),
      .rsp_resistance_ohms (rsp_resistance_ohms),
      .rsp_status          (rsp_status)
   );

endmodule

FILE: design/ttl_checker.sv
// Port-level checker for the thermistor lookup, bound to the top level.
`include "thermistor_temperature_lookup_macros.svh"

module ttl_checker import ttl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [TEMP_OUT_W-1:0] rsp_temperature_q8,
   input logic [RES_W-1:0]      rsp_resistance_ohms,
   input status_type            rsp_status
);

   `TTL_ASSERT_SAME(a_valid_in_busy, clock, reset, rsp_valid, busy, "result beat while not busy")
   `TTL_ASSERT_NEXT(a_valid_then_idle, clock, reset, rsp_valid, !busy && !rsp_valid, "no idle after result beat")
   `TTL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accepted beat did not hold busy")
   `TTL_ASSERT_SAME(a_zero_fields, clock, reset, rsp_valid && (rsp_status == STATUS_ZERO), (rsp_resistance_ohms == 16'hFFFF) && (rsp_temperature_q8 == '0), "zero sample fields wrong")
   `TTL_ASSERT_SAME(a_cold_temp, clock, reset, rsp_valid && (rsp_status == STATUS_COLD), rsp_temperature_q8 == '0, "cold clamp temperature not zero")

endmodule

bind thermistor_temperature_lookup ttl_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_temperature_q8  (rsp_temperature_q8),
   .rsp_resistance_ohms (rsp_resistance_ohms),
   .rsp_status          (rsp_status)
);
